// ===== rtl/esd_pkg.sv =====
// Shared types and constants for the escape sequence decoder.
package esd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_X_LOWER   = 8'h78;
    localparam logic [7:0] CH_X_UPPER   = 8'h58;

    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_BSPACE  = 8'h08;
    localparam logic [7:0] BYTE_FFEED   = 8'h0C;
    localparam logic [7:0] BYTE_BELL    = 8'h07;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_OCT,
        MODE_HEX
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_error;
        logic       out_last;
    } out_t;

    // One queue entry: the results of one input byte (one or two).
    typedef struct packed {
        logic two;
        out_t first;
        out_t second;
    } pair_t;

endpackage

// ===== rtl/escape_sequence_decoder.sv =====
// Top level of the C-style escape sequence decoder.
// A result passes through the result queue and then the output register to m_.
// Throughput: one input byte per cycle while the queue has room; a byte yielding
// two results holds the output register for two transfers, absorbed by the queue.
// Reset (aresetn low, synchronous): escape state to plain text, queue and
// output register emptied.
module escape_sequence_decoder #(
    parameter int QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  esd_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output esd_pkg::out_t   m_data
);

    // Front to queue: one entry per input byte that yields any result.
    logic            push;
    esd_pkg::pair_t  push_data;
    logic            q_full;

    // Queue to back end.
    logic            pop;
    esd_pkg::pair_t  pop_data;
    logic            q_empty;

    // Decode the byte stream; stall input only when the queue is full.
    esd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (push),
        .q_data  (push_data)
    );

    // Hold result pairs so the front keeps going while the output stalls.
    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (pop_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Split each pair into single-result transfers on the m_ channel.
    esd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/esd_front.sv =====
// Front end: accepts text bytes, tracks escape state, forms result pairs.
module esd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  esd_pkg::in_t     s_data,
    input  logic             q_full,
    output logic             q_push,
    output esd_pkg::pair_t   q_data
);

    esd_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     acc_reg, acc_next;
    logic [1:0]     dc_reg, dc_next;

    esd_pkg::out_t  res [2];
    logic [1:0]     n;
    logic           accept;

    always_comb begin
        logic [7:0] c;
        logic       is_oct;
        logic       is_hex;
        logic [3:0] hv;
        logic       do_plain;

        c        = s_data.in_byte;
        is_oct   = (c[7:3] == 5'b00110);
        is_hex   = 1'b0;
        hv       = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            is_hex = 1'b1;
            hv     = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            is_hex = 1'b1;
            hv     = c[3:0] + 4'd9;
        end

        mode_next = mode_reg;
        acc_next  = acc_reg;
        dc_next   = dc_reg;
        n         = 2'd0;
        do_plain  = 1'b0;
        res[0]    = '0;
        res[1]    = '0;

        case (mode_reg)
            esd_pkg::MODE_PLAIN: begin
                do_plain = 1'b1;
            end
            esd_pkg::MODE_ESC: begin
                mode_next = esd_pkg::MODE_PLAIN;
                case (c)
                    esd_pkg::CH_SQUOTE, esd_pkg::CH_DQUOTE,
                    esd_pkg::CH_BACKSLASH, esd_pkg::CH_QMARK: begin
                        res[0] = '{out_byte: c, out_error: 1'b0, out_last: 1'b0};
                        n = 2'd1;
                    end
                    esd_pkg::CH_N: begin
                        res[0] = '{out_byte: esd_pkg::BYTE_NEWLINE, out_error: 1'b0,
                                   out_last: 1'b0};
                        n = 2'd1;
                    end
                    esd_pkg::CH_T: begin
                        res[0] = '{out_byte: esd_pkg::BYTE_TAB, out_error: 1'b0,
                                   out_last: 1'b0};
                        n = 2'd1;
                    end
                    esd_pkg::CH_B: begin
                        res[0] = '{out_byte: esd_pkg::BYTE_BSPACE, out_error: 1'b0,
                                   out_last: 1'b0};
                        n = 2'd1;
                    end
                    esd_pkg::CH_F: begin
                        res[0] = '{out_byte: esd_pkg::BYTE_FFEED, out_error: 1'b0,
                                   out_last: 1'b0};
                        n = 2'd1;
                    end
                    esd_pkg::CH_A: begin
                        res[0] = '{out_byte: esd_pkg::BYTE_BELL, out_error: 1'b0,
                                   out_last: 1'b0};
                        n = 2'd1;
                    end
                    default: begin
                        if (is_oct) begin
                            mode_next = esd_pkg::MODE_OCT;
                            acc_next  = {5'd0, c[2:0]};
                            dc_next   = 2'd1;
                        end else if (c == esd_pkg::CH_X_LOWER || c == esd_pkg::CH_X_UPPER) begin
                            mode_next = esd_pkg::MODE_HEX;
                            acc_next  = c;
                            dc_next   = 2'd0;
                        end else begin
                            res[0] = '{out_byte: c, out_error: 1'b1, out_last: 1'b0};
                            n = 2'd1;
                        end
                    end
                endcase
            end
            esd_pkg::MODE_OCT: begin
                if (is_oct) begin
                    acc_next = {acc_reg[4:0], c[2:0]};
                    dc_next  = dc_reg + 2'd1;
                    if (dc_next == 2'd3) begin
                        res[0]    = '{out_byte: acc_next, out_error: 1'b0, out_last: 1'b0};
                        n         = 2'd1;
                        mode_next = esd_pkg::MODE_PLAIN;
                        acc_next  = 8'd0;
                        dc_next   = 2'd0;
                    end
                end else begin
                    res[0]    = '{out_byte: acc_reg, out_error: 1'b0, out_last: 1'b0};
                    n         = 2'd1;
                    mode_next = esd_pkg::MODE_PLAIN;
                    acc_next  = 8'd0;
                    dc_next   = 2'd0;
                    do_plain  = 1'b1;
                end
            end
            esd_pkg::MODE_HEX: begin
                if (is_hex) begin
                    acc_next = (dc_reg == 2'd0) ? {4'd0, hv} : {acc_reg[3:0], hv};
                    dc_next  = 2'd1;
                end else begin
                    res[0]    = '{out_byte: acc_reg, out_error: (dc_reg == 2'd0),
                                  out_last: 1'b0};
                    n         = 2'd1;
                    mode_next = esd_pkg::MODE_PLAIN;
                    acc_next  = 8'd0;
                    dc_next   = 2'd0;
                    do_plain  = 1'b1;
                end
            end
            default: begin
                mode_next = esd_pkg::MODE_PLAIN;
            end
        endcase

        // Handle the byte as plain text.
        if (do_plain) begin
            if (c == esd_pkg::CH_BACKSLASH) begin
                mode_next = esd_pkg::MODE_ESC;
            end else begin
                res[n[0]] = '{out_byte: c, out_error: 1'b0, out_last: 1'b0};
                n = n + 2'd1;
            end
        end

        // Flush whatever escape is still open at end of stream.
        if (s_data.in_last) begin
            case (mode_next)
                esd_pkg::MODE_ESC: begin
                    res[n[0]] = '{out_byte: esd_pkg::CH_BACKSLASH, out_error: 1'b1,
                                  out_last: 1'b0};
                    n = n + 2'd1;
                end
                esd_pkg::MODE_OCT: begin
                    res[n[0]] = '{out_byte: acc_next, out_error: 1'b0, out_last: 1'b0};
                    n = n + 2'd1;
                end
                esd_pkg::MODE_HEX: begin
                    res[n[0]] = '{out_byte: acc_next, out_error: (dc_next == 2'd0),
                                  out_last: 1'b0};
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
            mode_next = esd_pkg::MODE_PLAIN;
            acc_next  = 8'd0;
            dc_next   = 2'd0;
            if (n == 2'd2) begin
                res[1].out_last = 1'b1;
            end else begin
                res[0].out_last = 1'b1;
            end
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (n != 2'd0);
    assign q_data  = '{two: n[1], first: res[0], second: res[1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= esd_pkg::MODE_PLAIN;
            acc_reg  <= 8'd0;
            dc_reg   <= 2'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            dc_reg   <= dc_next;
        end
    end

endmodule

// ===== rtl/esd_queue.sv =====
// Small FIFO of result pairs between the front and back ends.
module esd_queue #(
    parameter int DEPTH = esd_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  esd_pkg::pair_t   wr_data,
    input  logic             pop,
    output esd_pkg::pair_t   rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    esd_pkg::pair_t entries [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/esd_back.sv =====
// Back end: drains result pairs one result per transfer into the output register.
module esd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  esd_pkg::pair_t   q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output esd_pkg::out_t    m_data
);

    logic           m_valid_reg, m_valid_next;
    esd_pkg::out_t  m_data_reg, m_data_next;
    logic           sec_valid_reg, sec_valid_next;
    esd_pkg::out_t  sec_reg, sec_next;
    logic           out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        sec_valid_next = sec_valid_reg;
        sec_next       = sec_reg;
        q_pop          = 1'b0;
        if (out_free) begin
            if (sec_valid_reg) begin
                m_data_next    = sec_reg;
                m_valid_next   = 1'b1;
                sec_valid_next = 1'b0;
            end else if (!q_empty) begin
                m_data_next    = q_data.first;
                m_valid_next   = 1'b1;
                sec_valid_next = q_data.two;
                sec_next       = q_data.second;
                q_pop          = 1'b1;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        sec_reg    <= sec_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
